/* src/tppe_pkg.sv */
// ----------------------------------------------------------------------------
// TCP port payload extractor package
// Shared widths, header offsets and configuration register indexes.
// ----------------------------------------------------------------------------
package tppe_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PORT_W     = 16;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_PORT    = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MAX_PAY = 8'd1;

  localparam logic [PORT_W-1:0] PORT_RESET    = 16'd0;
  localparam logic [LEN_W-1:0]  MAX_PAY_RESET = 11'd1400;

  localparam logic [BYTE_W-1:0] ETYPE_HI  = 8'h08;
  localparam logic [BYTE_W-1:0] ETYPE_LO  = 8'h00;
  localparam logic [BYTE_W-1:0] PROTO_TCP = 8'd6;

  localparam logic [POS_W-1:0] POS_ETYPE_HI = 16'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO = 16'd13;
  localparam logic [POS_W-1:0] POS_IHL      = 16'd14;
  localparam logic [POS_W-1:0] POS_TLEN_HI  = 16'd16;
  localparam logic [POS_W-1:0] POS_TLEN_LO  = 16'd17;
  localparam logic [POS_W-1:0] POS_PROTO    = 16'd23;
  localparam logic [POS_W-1:0] POS_MAX      = 16'hffff;

  localparam logic [6:0] ETH_HDR_BYTES = 7'd14;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

endpackage

/* src/tppe_in_if.sv */
// ----------------------------------------------------------------------------
// Frame byte channel
// Carries one Ethernet frame byte per transaction with a frame-end flag.
// ----------------------------------------------------------------------------
interface tppe_in_if;
  logic                             valid;
  logic                             ready;
  logic [tppe_pkg::BYTE_W-1:0]      frame_byte;
  logic                             frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

/* src/tppe_out_if.sv */
// ----------------------------------------------------------------------------
// Payload byte channel
// Carries one extracted TCP payload byte per transaction.
// ----------------------------------------------------------------------------
interface tppe_out_if;
  logic                             valid;
  logic                             ready;
  logic [tppe_pkg::BYTE_W-1:0]      payload_byte;
  logic [tppe_pkg::LEN_W-1:0]       payload_index;
  logic                             payload_last;

  modport source (output valid, output payload_byte, output payload_index,
                  output payload_last, input ready);
  modport sink   (input valid, input payload_byte, input payload_index,
                  input payload_last, output ready);
endinterface

/* src/tppe_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data per transaction.
// ----------------------------------------------------------------------------
interface tppe_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tppe_pkg::CFG_ADDR_W-1:0]    index;
  logic [tppe_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/tcp_port_payload_extractor_unit.sv */
// ----------------------------------------------------------------------------
// TCP port payload extractor
// Parses Ethernet/IPv4/TCP headers byte by byte and emits the payload bytes
// of frames whose TCP destination port matches the configured port.
// ----------------------------------------------------------------------------
// A payload byte appears on the output in the cycle after its frame byte
// is accepted. Throughput: one frame byte per cycle, limited only by the
// single output register draining. Reset (synchronous, active low) clears the
// parse state, empties the output register and loads the register defaults
// (port 0, which disables capture, and a 1400-byte payload limit).
module tcp_port_payload_extractor_unit (
  input  logic       clk,
  input  logic       rst_n,
  tppe_in_if.sink    in_ch,
  tppe_out_if.source out_ch,
  tppe_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic [tppe_pkg::PORT_W-1:0] port_r;
  logic [tppe_pkg::LEN_W-1:0]  max_pay_r;

  // Parse state.
  logic [tppe_pkg::POS_W-1:0]  pos_r,      pos_nxt;
  logic                        rej_r,      rej_nxt;
  logic [3:0]                  ihl_r,      ihl_nxt;
  logic [15:0]                 tot_len_r,  tot_len_nxt;
  logic [tppe_pkg::PORT_W-1:0] dport_r,    dport_nxt;
  logic [3:0]                  thw_r,      thw_nxt;
  logic [tppe_pkg::LEN_W-1:0]  remain_r,   remain_nxt;
  logic [tppe_pkg::LEN_W-1:0]  emit_cnt_r, emit_cnt_nxt;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  logic [tppe_pkg::BYTE_W-1:0] out_byte_r;
  logic [tppe_pkg::LEN_W-1:0]  out_index_r;
  logic                        out_last_r;

  logic                        in_accept;
  logic                        emit;
  logic                        emit_last;
  logic [tppe_pkg::BYTE_W-1:0] b;
  logic [6:0]                  tcp_start;
  logic [7:0]                  dport_hi_pos;
  logic [7:0]                  dport_lo_pos;
  logic [7:0]                  doff_pos;
  logic [7:0]                  pay_start;
  logic                        past_proto;
  logic [3:0]                  thw_new;
  logic [6:0]                  hdr_len;
  logic [15:0]                 len_full;
  logic [tppe_pkg::LEN_W-1:0]  len_lim;
  logic [tppe_pkg::PORT_W-1:0] dport_new;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign b            = in_ch.frame_byte;

  assign tcp_start    = tppe_pkg::ETH_HDR_BYTES + {1'b0, ihl_r, 2'b00};
  assign dport_hi_pos = {1'b0, tcp_start} + 8'd2;
  assign dport_lo_pos = {1'b0, tcp_start} + 8'd3;
  assign doff_pos     = {1'b0, tcp_start} + 8'd12;
  assign pay_start    = {1'b0, tcp_start} + {2'b00, thw_r, 2'b00};
  assign past_proto   = pos_r > tppe_pkg::POS_PROTO;

  assign thw_new   = b[7:4];
  assign hdr_len   = {1'b0, ihl_r, 2'b00} + {1'b0, thw_new, 2'b00};
  assign len_full  = tot_len_r - {9'd0, hdr_len};
  assign len_lim   = (len_full > {5'd0, max_pay_r}) ? max_pay_r
                                                    : len_full[tppe_pkg::LEN_W-1:0];
  assign dport_new = {dport_r[15:8], b};

  always_comb begin
    rej_nxt      = rej_r;
    ihl_nxt      = ihl_r;
    tot_len_nxt  = tot_len_r;
    dport_nxt    = dport_r;
    thw_nxt      = thw_r;
    remain_nxt   = remain_r;
    emit_cnt_nxt = emit_cnt_r;
    emit         = 1'b0;
    emit_last    = 1'b0;

    if (!rej_r) begin
      if (pos_r == tppe_pkg::POS_ETYPE_HI && b != tppe_pkg::ETYPE_HI) begin
        rej_nxt = 1'b1;
      end else if (pos_r == tppe_pkg::POS_ETYPE_LO && b != tppe_pkg::ETYPE_LO) begin
        rej_nxt = 1'b1;
      end else if (pos_r == tppe_pkg::POS_IHL) begin
        ihl_nxt = b[3:0];
        if (b[3:0] < tppe_pkg::MIN_HDR_WORDS) begin
          rej_nxt = 1'b1;
        end
      end else if (pos_r == tppe_pkg::POS_TLEN_HI) begin
        tot_len_nxt = {b, 8'd0};
      end else if (pos_r == tppe_pkg::POS_TLEN_LO) begin
        tot_len_nxt = {tot_len_r[15:8], b};
      end else if (pos_r == tppe_pkg::POS_PROTO && b != tppe_pkg::PROTO_TCP) begin
        rej_nxt = 1'b1;
      end else if (past_proto && pos_r == {8'd0, dport_hi_pos}) begin
        dport_nxt = {b, 8'd0};
      end else if (past_proto && pos_r == {8'd0, dport_lo_pos}) begin
        dport_nxt = dport_new;
        if (port_r == '0 || dport_new != port_r) begin
          rej_nxt = 1'b1;
        end
      end else if (past_proto && pos_r == {8'd0, doff_pos}) begin
        thw_nxt = thw_new;
        if (thw_new < tppe_pkg::MIN_HDR_WORDS) begin
          rej_nxt = 1'b1;
        end else if (tot_len_r <= {9'd0, hdr_len}) begin
          rej_nxt = 1'b1;
        end else begin
          remain_nxt = len_lim;
          if (len_lim == '0) begin
            rej_nxt = 1'b1;
          end
        end
      end else if (thw_r >= tppe_pkg::MIN_HDR_WORDS && remain_r != '0 &&
                   pos_r >= {8'd0, pay_start}) begin
        emit         = 1'b1;
        emit_last    = (remain_r == 11'd1) || in_ch.frame_end;
        emit_cnt_nxt = emit_cnt_r + 11'd1;
        remain_nxt   = remain_r - 11'd1;
        if (remain_r == 11'd1) begin
          rej_nxt = 1'b1;
        end
      end
    end

    pos_nxt = (pos_r != tppe_pkg::POS_MAX) ? pos_r + 16'd1 : pos_r;

    // The final byte of a frame returns the parser to its start state.
    if (in_ch.frame_end) begin
      pos_nxt      = '0;
      rej_nxt      = 1'b0;
      ihl_nxt      = '0;
      tot_len_nxt  = '0;
      dport_nxt    = '0;
      thw_nxt      = '0;
      remain_nxt   = '0;
      emit_cnt_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_r    <= tppe_pkg::PORT_RESET;
      max_pay_r <= tppe_pkg::MAX_PAY_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        tppe_pkg::CFG_IDX_PORT:    port_r    <= cfg_ch.data;
        tppe_pkg::CFG_IDX_MAX_PAY: max_pay_r <= cfg_ch.data[tppe_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      rej_r       <= 1'b0;
      ihl_r       <= '0;
      tot_len_r   <= '0;
      dport_r     <= '0;
      thw_r       <= '0;
      remain_r    <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        pos_r      <= pos_nxt;
        rej_r      <= rej_nxt;
        ihl_r      <= ihl_nxt;
        tot_len_r  <= tot_len_nxt;
        dport_r    <= dport_nxt;
        thw_r      <= thw_nxt;
        remain_r   <= remain_nxt;
        emit_cnt_r <= emit_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_byte_r  <= b;
      out_index_r <= emit_cnt_r;
      out_last_r  <= emit_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.payload_byte  = out_byte_r;
  assign out_ch.payload_index = out_index_r;
  assign out_ch.payload_last  = out_last_r;

endmodule
